/* sv/nmsx_pkg.sv */
// Shared types and constants of the 3x3 non-maximum suppression core.
// Used by the front, queue, back and top-level modules; depends on nothing.
package nmsx_pkg;

	typedef logic [1:0] nmsx_bin_t;

	typedef struct packed {
		logic produce;
		logic cmp_en;
		logic last;
	} nmsx_flags_t;

	localparam nmsx_bin_t BIN_0   = 2'd0;
	localparam nmsx_bin_t BIN_45  = 2'd1;
	localparam nmsx_bin_t BIN_90  = 2'd2;
	localparam nmsx_bin_t BIN_135 = 2'd3;

	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	localparam logic [11:0] RESET_WIDTH  = 12'd640;
	localparam logic [11:0] RESET_HEIGHT = 12'd480;
	localparam int          MAX_HEIGHT   = 2048;
	localparam int          ROW_BITS     = 12;
	localparam int          QUEUE_DEPTH  = 2;

	// Angles in Q3.12 radians: pi and the cut points of the four bins.
	localparam logic signed [15:0] PI_Q12  = 16'sd12868;
	localparam logic signed [15:0] CUT_22  = 16'sd1609;
	localparam logic signed [15:0] CUT_67  = 16'sd4826;
	localparam logic signed [15:0] CUT_112 = 16'sd8043;
	localparam logic signed [15:0] CUT_157 = 16'sd11260;

	function automatic nmsx_bin_t angle_bin(input logic signed [14:0] dir);
		logic signed [15:0] a0;
		logic signed [15:0] a1;
		logic signed [15:0] a2;
		logic signed [15:0] a3;
		nmsx_bin_t          b;
		a0 = 16'(dir);
		a1 = (a0 < 16'sd0) ? a0 + PI_Q12 : a0;
		a2 = (a1 < 16'sd0) ? a1 + PI_Q12 : a1;
		a3 = (a2 > PI_Q12) ? a2 - PI_Q12 : a2;
		if (a3 < CUT_22 || a3 >= CUT_157) begin
			b = BIN_0;
		end else if (a3 < CUT_67) begin
			b = BIN_45;
		end else if (a3 < CUT_112) begin
			b = BIN_90;
		end else begin
			b = BIN_135;
		end
		return b;
	endfunction

endpackage

/* sv/non_max_suppression_3x3_core.sv */
// Top level of the 3x3 non-maximum suppression core for Canny edge thinning.
// Instantiates nmsx_front, nmsx_queue and nmsx_back; depends on nmsx_pkg.
//
// Usage:
// Pixels arrive in raster order on the s_ channel, one item per pixel, with
// the gradient magnitude and the Q3.12 direction in s_tdata. s_tuser marks a
// flush item: after the width*height pixels of a frame, width+1 flush items
// drain the last results. Each item yields at most one result on the m_
// channel; the result belongs to the pixel one row plus one pixel earlier,
// so the first width+1 items of a frame yield nothing. m_tlast flags the
// result of the last pixel of the frame. Border pixels pass unchanged, and
// interior pixels are zeroed unless they are at least both neighbors along
// their binned gradient axis.
// Throughput is one item per clock unless the output stalls; each item does
// one read and one write of every line buffer. The releasing item goes through
// the queue and the s1 stage to the output register. When a result waits and
// m_tready is low, the output register holds, the back stage stops, and the
// two-entry queue fills before s_tready falls. The cfg channel is always ready
// and takes image_width (index 0) and image_height (index 1); write it while
// idle. Reset restores 640x480, clears the counters and window and empties the
// pipeline; line buffers need no clearing pass.
module non_max_suppression_3x3_core #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAG_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // magnitude[15:0], direction[30:16], zero[31]
	input  logic        s_tuser,   // flush
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // out_magnitude[15:0]
	output logic        m_tlast    // out_last
);
	import nmsx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = (MAG_BITS < 16) ? MAG_BITS : 16;
	localparam int FW = $bits(nmsx_flags_t);
	localparam int QW = CW + MW + 2 + FW;

	// Classified item from the front, before the queue.
	logic          f_valid;
	logic          f_ready;
	logic [CW-1:0] f_col;
	logic [MW-1:0] f_mag;
	nmsx_bin_t     f_bin;
	nmsx_flags_t   f_flags;

	// Item at the head of the queue, toward the back.
	logic          b_valid;
	logic          b_ready;
	logic [QW-1:0] b_data;

	nmsx_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAG_BITS (MAG_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.magnitude(s_tdata[15:0]),
		.direction(s_tdata[30:16]),
		.flush    (s_tuser),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_col    (f_col),
		.q_mag    (f_mag),
		.q_bin    (f_bin),
		.q_flags  (f_flags)
	);

	nmsx_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(f_valid),
		.push_ready(f_ready),
		.push_data ({f_flags, f_bin, f_mag, f_col}),
		.pop_valid (b_valid),
		.pop_ready (b_ready),
		.pop_data  (b_data)
	);

	nmsx_back #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAG_BITS (MAG_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (b_valid),
		.in_ready     (b_ready),
		.in_col       (b_data[CW-1:0]),
		.in_mag       (b_data[CW+MW-1:CW]),
		.in_bin       (b_data[CW+MW+1:CW+MW]),
		.in_flags     (b_data[QW-1:CW+MW+2]),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_magnitude(m_tdata),
		.out_last     (m_tlast)
	);

endmodule

/* sv/nmsx_front.sv */
// Front part of the suppression core: configuration registers, raster
// counters and per-item classification. Depends on nmsx_pkg.
module nmsx_front #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAG_BITS  = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [1:0]                  cfg_index,
	input  logic [11:0]                 cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [15:0]                 magnitude,
	input  logic signed [14:0]          direction,
	input  logic                        flush,
	output logic                        q_valid,
	input  logic                        q_ready,
	output logic [$clog2(MAX_WIDTH)-1:0] q_col,
	output logic [((MAG_BITS < 16) ? MAG_BITS : 16)-1:0] q_mag,
	output nmsx_pkg::nmsx_bin_t         q_bin,
	output nmsx_pkg::nmsx_flags_t       q_flags
);
	import nmsx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = (MAG_BITS < 16) ? MAG_BITS : 16;
	localparam int LW = (CW + 1 > 14) ? CW + 1 : 14;

	logic [11:0]         width_q;
	logic [11:0]         height_q;
	logic [CW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;

	logic [LW-1:0] w_val;
	logic [LW-1:0] h_val;
	logic [LW-1:0] wq_ext;
	logic [LW-1:0] hq_ext;
	logic [LW-1:0] col_ext;
	logic [LW-1:0] col_eff;
	logic [LW-1:0] row_ext;
	logic          in_frame;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = q_ready;
	assign q_valid   = in_valid;
	assign accept    = in_valid && q_ready;

	always_comb begin
		wq_ext  = LW'(width_q);
		hq_ext  = LW'(height_q);
		w_val   = (wq_ext < LW'(3)) ? LW'(3) :
		          ((wq_ext > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : wq_ext);
		h_val   = (hq_ext < LW'(3)) ? LW'(3) :
		          ((hq_ext > LW'(MAX_HEIGHT)) ? LW'(MAX_HEIGHT) : hq_ext);
		col_ext = LW'(col_q);
		col_eff = (col_ext >= LW'(MAX_WIDTH)) ? '0 : col_ext;
		row_ext = LW'(row_q);

		in_frame = !flush && (row_ext < h_val);
		q_col    = CW'(col_eff);
		q_mag    = in_frame ? magnitude[MW-1:0] : '0;
		q_bin    = angle_bin(in_frame ? direction : 15'sd0);

		// Position of the centre pixel that this item completes.
		if (col_eff >= LW'(1)) begin
			q_flags.produce = (row_ext >= LW'(1)) && (row_ext <= h_val);
			q_flags.last    = (row_ext == h_val) && (col_eff == w_val);
		end else begin
			q_flags.produce = (row_ext >= LW'(2)) && (row_ext <= h_val + LW'(1));
			q_flags.last    = (row_ext == h_val + LW'(1));
		end
		q_flags.cmp_en = (col_eff >= LW'(2)) && (col_eff < w_val) &&
		                 (row_ext >= LW'(2)) && (row_ext < h_val);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  width_q  <= cfg_data;
				CFG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_ext >= h_val + LW'(1)) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_eff + LW'(1) >= w_val) begin
				col_q <= '0;
				row_q <= row_q + ROW_BITS'(1);
			end else begin
				col_q <= CW'(col_eff + LW'(1));
			end
		end
	end

endmodule

/* sv/nmsx_queue.sv */
// Short register queue that parts the front from the back of the core.
// Depends on nmsx_pkg for its depth.
module nmsx_queue #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);
	import nmsx_pkg::*;

	localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNW = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CNW-1:0]   count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CNW'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			count_q <= count_q + CNW'(push) - CNW'(pop);
		end
	end

endmodule

/* sv/nmsx_back.sv */
// Back part of the suppression core: line buffers, the 3x3 window, the
// neighbor compare and the output register. Depends on nmsx_pkg.
module nmsx_back #(
	parameter int MAX_WIDTH = 2048,
	parameter int MAG_BITS  = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [$clog2(MAX_WIDTH)-1:0] in_col,
	input  logic [((MAG_BITS < 16) ? MAG_BITS : 16)-1:0] in_mag,
	input  nmsx_pkg::nmsx_bin_t          in_bin,
	input  nmsx_pkg::nmsx_flags_t        in_flags,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [15:0]                  out_magnitude,
	output logic                         out_last
);
	import nmsx_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int MW = (MAG_BITS < 16) ? MAG_BITS : 16;

	logic [MW-1:0] upper_mem  [MAX_WIDTH];
	logic [MW-1:0] middle_mem [MAX_WIDTH];
	nmsx_bin_t     bins_mem   [MAX_WIDTH];

	logic          s1_valid_q;
	logic [CW-1:0] col_s1;
	logic [MW-1:0] mag_s1;
	nmsx_bin_t     bin_s1;
	nmsx_flags_t   flags_s1;
	logic [MW-1:0] top_rd_s1;
	logic [MW-1:0] mid_rd_s1;
	nmsx_bin_t     binrd_s1;
	logic          byp_s1;
	logic [MW-1:0] byp_top_s1;
	logic [MW-1:0] byp_mid_s1;
	nmsx_bin_t     byp_bin_s1;

	logic [MW-1:0] win_q [6];
	nmsx_bin_t     pend_q;
	logic          out_valid_q;
	logic [MW-1:0] out_mag_q;
	logic          out_last_q;

	logic          adv;
	logic          pop;
	logic          s1_fire;
	logic [MW-1:0] top_c;
	logic [MW-1:0] mid_c;
	nmsx_bin_t     bin_c;
	logic [MW-1:0] nb_q;
	logic [MW-1:0] nb_r;
	logic [MW-1:0] result;

	assign adv       = !out_valid_q || out_ready;
	assign in_ready  = !s1_valid_q || adv;
	assign pop       = in_valid && in_ready;
	assign s1_fire   = s1_valid_q && adv;

	assign out_valid     = out_valid_q;
	assign out_magnitude = 16'(out_mag_q);
	assign out_last      = out_last_q;

	always_comb begin
		// A read that hit the entry written in the same cycle takes the new data.
		top_c = byp_s1 ? byp_top_s1 : top_rd_s1;
		mid_c = byp_s1 ? byp_mid_s1 : mid_rd_s1;
		bin_c = byp_s1 ? byp_bin_s1 : binrd_s1;
		case (pend_q)
			BIN_0: begin
				nb_q = win_q[4];
				nb_r = mid_c;
			end
			BIN_45: begin
				nb_q = win_q[5];
				nb_r = top_c;
			end
			BIN_90: begin
				nb_q = win_q[0];
				nb_r = win_q[2];
			end
			default: begin
				nb_q = win_q[3];
				nb_r = mag_s1;
			end
		endcase
		result = (flags_s1.cmp_en && !(win_q[1] >= nb_q && win_q[1] >= nb_r)) ?
		         '0 : win_q[1];
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			upper_mem[col_s1]  <= mid_c;
			middle_mem[col_s1] <= mag_s1;
			bins_mem[col_s1]   <= bin_s1;
		end
		if (pop) begin
			top_rd_s1 <= upper_mem[in_col];
			mid_rd_s1 <= middle_mem[in_col];
			binrd_s1  <= bins_mem[in_col];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_s1     <= in_col;
			mag_s1     <= in_mag;
			bin_s1     <= in_bin;
			flags_s1   <= in_flags;
			byp_s1     <= s1_fire && (col_s1 == in_col);
			byp_top_s1 <= mid_c;
			byp_mid_s1 <= mag_s1;
			byp_bin_s1 <= bin_s1;
		end
		if (s1_fire && flags_s1.produce) begin
			out_mag_q  <= result;
			out_last_q <= flags_s1.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= BIN_0;
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_fire && flags_s1.produce) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				win_q[3] <= win_q[0];
				win_q[4] <= win_q[1];
				win_q[5] <= win_q[2];
				win_q[0] <= top_c;
				win_q[1] <= mid_c;
				win_q[2] <= mag_s1;
				pend_q   <= bin_c;
			end
		end
	end

endmodule
